// ----- design/chps_pkg.sv -----
// Package for the channel histogram peak scale block.
// Holds field widths, register indexes, mode codes, reset values and the lane control struct.
// Depends on nothing; every design file imports it.
package chps_pkg;

   localparam int BIN_COUNT_DEF = 256;
   localparam int COUNT_BITS_DEF = 20;
   localparam int CHANNELS_DEF = 3;

   localparam int SAMPLE_BITS = 8;
   localparam int ROWS_BITS = 8;
   localparam int CHCNT_BITS = 2;
   localparam int COUNT_FIELD_BITS = 20;
   localparam int HEIGHT_BITS = 8;
   localparam int MODE_BITS = 2;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS = 8;
   localparam int OUT_LANES = 3;

   localparam logic [COUNT_FIELD_BITS-1:0] COUNT_FIELD_MAX = '1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL_COUNT = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CANVAS_ROWS = 1'd1;

   localparam logic [CHCNT_BITS-1:0] CHANNEL_COUNT_RST = 2'd3;
   localparam logic [ROWS_BITS-1:0] CANVAS_ROWS_RST = 8'd125;

   localparam logic [MODE_BITS-1:0] MODE_ACC = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_READ = 2'd2;

   typedef struct packed {
      logic load;
      logic is_read;
      logic capture;
      logic div_init;
      logic div_step;
      logic clear;
   } lane_ctrl_type;

endpackage

// ----- design/channel_histogram_peak_scale_core.sv -----
// Top level of the channel histogram peak scale block.
// Holds the sequencer, the configuration registers and the result register.
// Depends on chps_pkg and chps_lane.
//
// Usage:
// Each transfer on the req_ channel carries a mode. Mode 0 adds one pixel to the
// histogram of every channel in use, mode 1 clears all bins and peaks, and mode 2
// reads one bin of every channel. Only mode 2 produces a transfer on the rsp_
// channel, with the raw counts and the bar heights count*rows/peak.
// Accumulate transfers are taken one per cycle while no clear or read is in progress;
// a read-modify-write of the bin memory is forwarded when consecutive pixels hit the same bin.
// A read passes through the bin memory read, the multiplier and the shift-subtract
// divider, which finds one bit of height per cycle, before rsp_valid is raised.
// A clear clears one bin per cycle and holds req_ready low while it runs.
// After reset the same clearing pass runs before the first request is taken;
// configuration writes are taken at any time.
// A finished read result waits in the lanes until the output register is free,
// and then in the output register while the receiver stalls; no request is
// taken until the result has moved into the output register.
module channel_histogram_peak_scale_core
   #(parameter int BIN_COUNT = chps_pkg::BIN_COUNT_DEF,
     parameter int COUNT_BITS = chps_pkg::COUNT_BITS_DEF,
     parameter int CHANNELS = chps_pkg::CHANNELS_DEF)
   (input  logic                                   clock,
    input  logic                                   reset,
    input  logic                                   req_valid,
    output logic                                   req_ready,
    input  logic [chps_pkg::MODE_BITS-1:0]         req_mode,
    input  logic [chps_pkg::SAMPLE_BITS-1:0]       req_first_sample,
    input  logic [chps_pkg::SAMPLE_BITS-1:0]       req_second_sample,
    input  logic [chps_pkg::SAMPLE_BITS-1:0]       req_third_sample,
    input  logic [chps_pkg::SAMPLE_BITS-1:0]       req_bin_index,
    output logic                                   rsp_valid,
    input  logic                                   rsp_ready,
    output logic [chps_pkg::COUNT_FIELD_BITS-1:0]  rsp_first_count,
    output logic [chps_pkg::COUNT_FIELD_BITS-1:0]  rsp_second_count,
    output logic [chps_pkg::COUNT_FIELD_BITS-1:0]  rsp_third_count,
    output logic [chps_pkg::HEIGHT_BITS-1:0]       rsp_first_height,
    output logic [chps_pkg::HEIGHT_BITS-1:0]       rsp_second_height,
    output logic [chps_pkg::HEIGHT_BITS-1:0]       rsp_third_height,
    input  logic                                   csr_write_enable,
    input  logic [chps_pkg::CSR_INDEX_BITS-1:0]    csr_index,
    input  logic [chps_pkg::CSR_DATA_BITS-1:0]     csr_write_data);

   import chps_pkg::*;

   localparam int ADDR_BITS = $clog2(BIN_COUNT);
   localparam int STEP_BITS = $clog2(HEIGHT_BITS);
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(BIN_COUNT - 1);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(HEIGHT_BITS - 1);
   localparam logic [CHCNT_BITS-1:0] CHANNELS_MAX = CHCNT_BITS'(CHANNELS);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_RUN   = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_HOLD  = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   logic [ADDR_BITS-1:0]     clr_addr_ff, clr_addr_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic                     s1_read_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_load;
   logic [CHCNT_BITS-1:0]    channel_count_ff;
   logic [ROWS_BITS-1:0]     canvas_rows_ff;
   logic [CHCNT_BITS-1:0]    active_count;
   logic                     accept;
   lane_ctrl_type            lane_ctrl;

   logic [SAMPLE_BITS-1:0]      samples [OUT_LANES];
   logic [COUNT_FIELD_BITS-1:0] lane_count [OUT_LANES];
   logic [HEIGHT_BITS-1:0]      lane_height [OUT_LANES];
   logic [COUNT_FIELD_BITS-1:0] rsp_count_ff [OUT_LANES];
   logic [HEIGHT_BITS-1:0]      rsp_height_ff [OUT_LANES];

   assign samples[0] = req_first_sample;
   assign samples[1] = req_second_sample;
   assign samples[2] = req_third_sample;

   always_comb begin
      if (channel_count_ff == '0) begin
         active_count = CHCNT_BITS'(1);
      end else if (channel_count_ff > CHANNELS_MAX) begin
         active_count = CHANNELS_MAX;
      end else begin
         active_count = channel_count_ff;
      end
   end

   assign req_ready = (state_ff == ST_RUN) && !s1_read_ff;
   assign accept = req_valid && req_ready;

   assign lane_ctrl.load = accept && ((req_mode == MODE_ACC) || (req_mode == MODE_READ));
   assign lane_ctrl.is_read = (req_mode == MODE_READ);
   assign lane_ctrl.capture = s1_read_ff;
   assign lane_ctrl.div_init = (state_ff == ST_MUL);
   assign lane_ctrl.div_step = (state_ff == ST_DIV);
   assign lane_ctrl.clear = (state_ff == ST_CLEAR);

   assign rsp_load = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      clr_addr_in = clr_addr_ff;
      step_in = step_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_BITS'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (accept && (req_mode == MODE_CLEAR)) begin
               state_in = ST_CLEAR;
               clr_addr_in = '0;
            end else if (s1_read_ff) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
            step_in = '0;
         end
         ST_DIV: begin
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_load) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_addr_in = '0;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_addr_ff <= '0;
         step_ff <= '0;
         s1_read_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         channel_count_ff <= CHANNEL_COUNT_RST;
         canvas_rows_ff <= CANVAS_ROWS_RST;
      end else begin
         state_ff <= state_in;
         clr_addr_ff <= clr_addr_in;
         step_ff <= step_in;
         s1_read_ff <= accept && (req_mode == MODE_READ);
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CHANNEL_COUNT: channel_count_ff <= csr_write_data[CHCNT_BITS-1:0];
               CSR_CANVAS_ROWS:   canvas_rows_ff <= csr_write_data[ROWS_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   genvar ch;
   generate
      for (ch = 0; ch < OUT_LANES; ch++) begin : g_lane
         if (ch < CHANNELS) begin : g_used
            chps_lane #(
               .BIN_COUNT  (BIN_COUNT),
               .COUNT_BITS (COUNT_BITS)
            ) u_lane (
               .clock       (clock),
               .reset       (reset),
               .ctrl        (lane_ctrl),
               .lane_on     (CHCNT_BITS'(ch) < active_count),
               .sample      (samples[ch]),
               .bin_index   (req_bin_index),
               .canvas_rows (canvas_rows_ff),
               .clear_addr  (clr_addr_ff),
               .count       (lane_count[ch]),
               .height      (lane_height[ch])
            );
         end else begin : g_unused
            assign lane_count[ch] = '0;
            assign lane_height[ch] = '0;
         end

         always_ff @(posedge clock) begin
            if (rsp_load) begin
               rsp_count_ff[ch] <= lane_count[ch];
               rsp_height_ff[ch] <= lane_height[ch];
            end
         end
      end
   endgenerate

   assign rsp_valid = rsp_valid_ff;
   assign rsp_first_count = rsp_count_ff[0];
   assign rsp_second_count = rsp_count_ff[1];
   assign rsp_third_count = rsp_count_ff[2];
   assign rsp_first_height = rsp_height_ff[0];
   assign rsp_second_height = rsp_height_ff[1];
   assign rsp_third_height = rsp_height_ff[2];

endmodule

// ----- design/chps_lane.sv -----
// One channel of the histogram: bin memory, read-modify-write with forwarding,
// peak tracking and the bar height multiply and shift-subtract divider.
// Depends on chps_pkg.
module chps_lane
   #(parameter int BIN_COUNT = chps_pkg::BIN_COUNT_DEF,
     parameter int COUNT_BITS = chps_pkg::COUNT_BITS_DEF)
   (input  logic                                    clock,
    input  logic                                    reset,
    input  chps_pkg::lane_ctrl_type                 ctrl,
    input  logic                                    lane_on,
    input  logic [chps_pkg::SAMPLE_BITS-1:0]        sample,
    input  logic [chps_pkg::SAMPLE_BITS-1:0]        bin_index,
    input  logic [chps_pkg::ROWS_BITS-1:0]          canvas_rows,
    input  logic [$clog2(BIN_COUNT)-1:0]            clear_addr,
    output logic [chps_pkg::COUNT_FIELD_BITS-1:0]   count,
    output logic [chps_pkg::HEIGHT_BITS-1:0]        height);

   import chps_pkg::*;

   localparam int ADDR_BITS = $clog2(BIN_COUNT);
   localparam int PROD_BITS = COUNT_BITS + ROWS_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [COUNT_BITS-1:0] bins_mem [BIN_COUNT];

   logic [SAMPLE_BITS-1:0] key;
   logic [ADDR_BITS-1:0]   key_addr;
   logic                   key_in_range;
   logic [COUNT_BITS-1:0]  cur_count;
   logic [COUNT_BITS-1:0]  new_count;

   logic [COUNT_BITS-1:0]  rd_data_ff;
   logic [COUNT_BITS-1:0]  fwd_data_ff;
   logic                   fwd_ff;
   logic                   s1_write_ff;
   logic                   s1_en_ff;
   logic [ADDR_BITS-1:0]   s1_addr_ff;
   logic [COUNT_BITS-1:0]  peak_ff;
   logic [COUNT_BITS-1:0]  cnt_ff;
   logic [PROD_BITS-1:0]   rem_ff;
   logic [PROD_BITS-1:0]   dsh_ff;
   logic [HEIGHT_BITS-1:0] quo_ff;

   assign key = ctrl.is_read ? bin_index : sample;
   assign key_addr = key[ADDR_BITS-1:0];
   assign key_in_range = {1'b0, key} < (SAMPLE_BITS + 1)'(BIN_COUNT);
   assign cur_count = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign new_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_BITS'(1);

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         bins_mem[clear_addr] <= '0;
      end else if (s1_write_ff) begin
         bins_mem[s1_addr_ff] <= new_count;
      end
      if (ctrl.load) begin
         rd_data_ff <= bins_mem[key_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_write_ff <= 1'b0;
         fwd_ff <= 1'b0;
         peak_ff <= '0;
      end else begin
         s1_write_ff <= ctrl.load && !ctrl.is_read && lane_on && key_in_range;
         fwd_ff <= ctrl.load && s1_write_ff && (s1_addr_ff == key_addr);
         if (ctrl.clear) begin
            peak_ff <= '0;
         end else if (s1_write_ff && (new_count > peak_ff)) begin
            peak_ff <= new_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= new_count;
      if (ctrl.load) begin
         s1_addr_ff <= key_addr;
         s1_en_ff <= lane_on && key_in_range;
      end
      if (ctrl.capture) begin
         cnt_ff <= s1_en_ff ? cur_count : '0;
      end
      if (ctrl.div_init) begin
         rem_ff <= PROD_BITS'(cnt_ff) * PROD_BITS'(canvas_rows);
         dsh_ff <= PROD_BITS'(peak_ff) << (HEIGHT_BITS - 1);
         quo_ff <= '0;
      end else if (ctrl.div_step) begin
         if (rem_ff >= dsh_ff) begin
            rem_ff <= rem_ff - dsh_ff;
            quo_ff <= {quo_ff[HEIGHT_BITS-2:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[HEIGHT_BITS-2:0], 1'b0};
         end
         dsh_ff <= dsh_ff >> 1;
      end
   end

   generate
      if (COUNT_BITS <= COUNT_FIELD_BITS) begin : g_count_fits
         assign count = COUNT_FIELD_BITS'(cnt_ff);
      end else begin : g_count_clamp
         assign count = (cnt_ff > COUNT_BITS'(COUNT_FIELD_MAX)) ?
                        COUNT_FIELD_MAX : cnt_ff[COUNT_FIELD_BITS-1:0];
      end
   endgenerate

   assign height = (peak_ff == '0) ? '0 : quo_ff;

endmodule
